// ===== hdl/quaternion_boxplus_boxminus_assert.svh =====
`ifndef QUATERNION_BOXPLUS_BOXMINUS_ASSERT_SVH
`define QUATERNION_BOXPLUS_BOXMINUS_ASSERT_SVH

// same-cycle implication
`define QBB_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("qbb assertion failed");

// next-cycle implication
`define QBB_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("qbb assertion failed");

`endif

// ===== hdl/qbb_pkg.sv =====
package qbb_pkg;

    localparam logic MODE_MINUS = 1'b1;
    localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;
    localparam int unsigned FifoDepth = 2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] base_w;
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
        logic signed [31:0] arg_w;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [31:0] arg_z;
    } qbb_in_t;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } qbb_out_t;

    typedef struct packed {
        logic               mode;
        logic signed [32:0] a0;
        logic signed [32:0] a1;
        logic signed [32:0] a2;
        logic signed [32:0] a3;
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] b3;
    } qbb_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qbb_fifo_stat_t;

endpackage

// ===== hdl/qbb_front.sv =====
module qbb_front
    import qbb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  qbb_in_t        item,
    input  qbb_fifo_stat_t fifo_stat,
    output logic           push,
    output qbb_op_t        op
);

    logic    valid_reg;
    logic    valid_next;
    qbb_op_t op_reg;
    qbb_op_t op_next;
    logic    accept;
    logic    minus;

    assign busy   = valid_reg && fifo_stat.full;
    assign accept = start && !busy;
    assign push   = valid_reg && !fifo_stat.full;
    assign op     = op_reg;
    assign minus  = (item.mode == MODE_MINUS);

    // conjugate the base in minus mode, unit scalar delta in plus mode
    always_comb
    begin
        op_next.mode = item.mode;
        op_next.a0   = 33'(item.base_w);
        op_next.a1   = minus ? -33'(item.base_x) : 33'(item.base_x);
        op_next.a2   = minus ? -33'(item.base_y) : 33'(item.base_y);
        op_next.a3   = minus ? -33'(item.base_z) : 33'(item.base_z);
        op_next.b0   = minus ? item.arg_w : OneQ30;
        op_next.b1   = item.arg_x;
        op_next.b2   = item.arg_y;
        op_next.b3   = item.arg_z;
        valid_next   = accept || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

// ===== hdl/qbb_fifo.sv =====
module qbb_fifo
    import qbb_pkg::*;
#(
    parameter int unsigned DEPTH = FifoDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qbb_op_t        wr_data,
    input  logic           pop,
    output qbb_op_t        rd_data,
    output qbb_fifo_stat_t stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    qbb_op_t         mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == CntW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/qbb_back.sv =====
module qbb_back
    import qbb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    input  qbb_op_t  op,
    output logic     done,
    output qbb_out_t result
);

    localparam int SqrtSteps = 31;
    localparam int DivSteps  = 32;

    // stage 1: partial products
    logic signed [32:0] av [4];
    logic signed [31:0] bv [4];
    logic signed [64:0] pf [4][4];
    logic signed [62:0] prod_reg [4][4];
    logic               mode1_reg;
    logic               vld1_reg;

    assign av[0] = op.a0;
    assign av[1] = op.a1;
    assign av[2] = op.a2;
    assign av[3] = op.a3;
    assign bv[0] = op.b0;
    assign bv[1] = op.b1;
    assign bv[2] = op.b2;
    assign bv[3] = op.b3;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pf[i][j] = 65'(av[i]) * 65'(bv[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[i][j] <= pf[i][j][64:2];
            end
        end
        mode1_reg <= op.mode;
    end

    // stage 2: hamilton sums
    logic signed [64:0] c2_reg [4];
    logic               mode2_reg;
    logic               vld2_reg;

    always_ff @(posedge clk)
    begin
        c2_reg[0] <= 65'(prod_reg[0][0]) - 65'(prod_reg[1][1])
                   - 65'(prod_reg[2][2]) - 65'(prod_reg[3][3]);
        c2_reg[1] <= 65'(prod_reg[0][1]) + 65'(prod_reg[1][0])
                   + 65'(prod_reg[2][3]) - 65'(prod_reg[3][2]);
        c2_reg[2] <= 65'(prod_reg[0][2]) - 65'(prod_reg[1][3])
                   + 65'(prod_reg[2][0]) + 65'(prod_reg[3][1]);
        c2_reg[3] <= 65'(prod_reg[0][3]) + 65'(prod_reg[1][2])
                   - 65'(prod_reg[2][1]) + 65'(prod_reg[3][0]);
        mode2_reg <= mode1_reg;
    end

    // stage 3: magnitude union
    logic [64:0]        cabs [4];
    logic [63:0]        or3_reg;
    logic signed [64:0] c3_reg [4];
    logic               mode3_reg;
    logic               vld3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cabs[i] = c2_reg[i][64] ? 65'(-c2_reg[i]) : 65'(c2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        or3_reg   <= cabs[0][63:0] | cabs[1][63:0] | cabs[2][63:0] | cabs[3][63:0];
        c3_reg    <= c2_reg;
        mode3_reg <= mode2_reg;
    end

    // stage 4: bit length of the largest magnitude
    logic [6:0]         len;
    logic [6:0]         len4_reg;
    logic signed [64:0] c4_reg [4];
    logic               mode4_reg;
    logic               vld4_reg;

    always_comb
    begin
        len = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (or3_reg[k])
            begin
                len = 7'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len4_reg  <= len;
        c4_reg    <= c3_reg;
        mode4_reg <= mode3_reg;
    end

    // stage 5: scale to a 30-bit peak
    logic signed [64:0] vsh [4];
    logic signed [31:0] v5_reg [4];
    logic               mode5_reg;
    logic               vld5_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (len4_reg > 7'd30)
            begin
                vsh[i] = c4_reg[i] >>> (len4_reg - 7'd30);
            end
            else
            begin
                vsh[i] = c4_reg[i] <<< (7'd30 - len4_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            v5_reg[i] <= vsh[i][31:0];
        end
        mode5_reg <= mode4_reg;
    end

    // stage 6: squares
    logic signed [63:0] sqf [4];
    logic [60:0]        sq6_reg [4];
    logic signed [31:0] v6_reg [4];
    logic               mode6_reg;
    logic               vld6_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sqf[i] = 64'(v5_reg[i]) * 64'(v5_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq6_reg[i] <= sqf[i][60:0];
        end
        v6_reg    <= v5_reg;
        mode6_reg <= mode5_reg;
    end

    // square root, one root bit per stage
    logic [62:0]        srem_reg  [SqrtSteps+1];
    logic [30:0]        sroot_reg [SqrtSteps+1];
    logic signed [31:0] sv_reg    [SqrtSteps+1][4];
    logic               smode_reg [SqrtSteps+1];
    logic               svld_reg  [SqrtSteps+1];

    always_ff @(posedge clk)
    begin
        srem_reg[0]  <= 63'(sq6_reg[0]) + 63'(sq6_reg[1]) + 63'(sq6_reg[2]) + 63'(sq6_reg[3]);
        sroot_reg[0] <= '0;
        sv_reg[0]    <= v6_reg;
        smode_reg[0] <= mode6_reg;
    end

    for (genvar g = 0; g < SqrtSteps; g++)
    begin : g_sqrt
        localparam int Pos = SqrtSteps - 1 - g;
        logic [63:0] trial;
        logic        fits;

        assign trial = ({33'b0, sroot_reg[g]} << (Pos + 1)) + (64'b1 << (2 * Pos));
        assign fits  = ({1'b0, srem_reg[g]} >= trial);

        always_ff @(posedge clk)
        begin
            srem_reg[g+1]  <= fits ? srem_reg[g] - trial[62:0] : srem_reg[g];
            sroot_reg[g+1] <= fits ? sroot_reg[g] | (31'b1 << Pos) : sroot_reg[g];
            sv_reg[g+1]    <= sv_reg[g];
            smode_reg[g+1] <= smode_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                svld_reg[g+1] <= 1'b0;
            end
            else
            begin
                svld_reg[g+1] <= svld_reg[g];
            end
        end
    end

    // divider setup
    logic [30:0] nrm;
    logic [30:0] mag  [4];
    logic [61:0] num  [4];

    assign nrm = (sroot_reg[SqrtSteps] == '0) ? 31'd1 : sroot_reg[SqrtSteps];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = sv_reg[SqrtSteps][i][31] ? 31'(-33'(sv_reg[SqrtSteps][i]))
                                              : 31'(sv_reg[SqrtSteps][i]);
            if (smode_reg[SqrtSteps] == MODE_MINUS)
            begin
                num[i] = ({31'b0, mag[i]} << 30) + 62'(nrm >> 1);
            end
            else
            begin
                num[i] = ({31'b0, mag[i]} << 29) + 62'(nrm >> 1);
            end
        end
    end

    // restoring division, one quotient bit per stage per lane
    logic [30:0] drem_reg  [DivSteps+1][4];
    logic [31:0] dlo_reg   [DivSteps+1][4];
    logic [31:0] dq_reg    [DivSteps+1][4];
    logic        dneg_reg  [DivSteps+1][4];
    logic [30:0] dn_reg    [DivSteps+1];
    logic        dmode_reg [DivSteps+1];
    logic        dvld_reg  [DivSteps+1];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            drem_reg[0][i] <= {1'b0, num[i][61:32]};
            dlo_reg[0][i]  <= num[i][31:0];
            dq_reg[0][i]   <= '0;
            dneg_reg[0][i] <= sv_reg[SqrtSteps][i][31];
        end
        dn_reg[0]    <= nrm;
        dmode_reg[0] <= smode_reg[SqrtSteps];
    end

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        logic [31:0] part [4];
        logic        ge   [4];

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                part[i] = {drem_reg[g][i], dlo_reg[g][i][31]};
                ge[i]   = (part[i] >= {1'b0, dn_reg[g]});
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 4; i++)
            begin
                drem_reg[g+1][i] <= ge[i] ? 31'(part[i] - {1'b0, dn_reg[g]}) : part[i][30:0];
                dlo_reg[g+1][i]  <= {dlo_reg[g][i][30:0], 1'b0};
                dq_reg[g+1][i]   <= {dq_reg[g][i][30:0], ge[i]};
                dneg_reg[g+1][i] <= dneg_reg[g][i];
            end
            dn_reg[g+1]    <= dn_reg[g];
            dmode_reg[g+1] <= dmode_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld_reg[g+1] <= 1'b0;
            end
            else
            begin
                dvld_reg[g+1] <= dvld_reg[g];
            end
        end
    end

    // sign restore and saturation
    logic signed [31:0] fin [4];
    qbb_out_t           result_reg;
    qbb_out_t           result_next;
    logic               done_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dneg_reg[DivSteps][i])
            begin
                fin[i] = (dq_reg[DivSteps][i] >= 32'h8000_0000) ? 32'sh8000_0000
                                                                  : -$signed(dq_reg[DivSteps][i]);
            end
            else
            begin
                fin[i] = (dq_reg[DivSteps][i] > 32'h7fff_ffff) ? 32'sh7fff_ffff
                                                                 : $signed(dq_reg[DivSteps][i]);
            end
        end
        result_next.out_w = (dmode_reg[DivSteps] == MODE_MINUS) ? '0 : fin[0];
        result_next.out_x = fin[1];
        result_next.out_y = fin[2];
        result_next.out_z = fin[3];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            vld6_reg    <= 1'b0;
            svld_reg[0] <= 1'b0;
            dvld_reg[0] <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            vld1_reg    <= op_valid;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            vld5_reg    <= vld4_reg;
            vld6_reg    <= vld5_reg;
            svld_reg[0] <= vld6_reg;
            dvld_reg[0] <= svld_reg[SqrtSteps];
            done_reg    <= dvld_reg[DivSteps];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/quaternion_boxplus_boxminus.sv =====
// path: front register, queue, back stages, square root, divider, result register
// throughput: one item per cycle, set by the fully pipelined square root and divider
// busy stays low in normal use since the back end drains the queue every cycle
// reset: asynchronous, active low; clears all valid flags, no result pending
module quaternion_boxplus_boxminus
    import qbb_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FifoDepth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  qbb_in_t  item,
    output logic     done,
    output qbb_out_t result
);

    qbb_fifo_stat_t fstat;
    qbb_op_t        front_op;
    qbb_op_t        back_op;
    logic           push;
    logic           pop;

    assign pop = !fstat.empty;

    qbb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .fifo_stat (fstat),
        .push      (push),
        .op        (front_op)
    );

    qbb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_op),
        .pop     (pop),
        .rd_data (back_op),
        .stat    (fstat)
    );

    qbb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (pop),
        .op       (back_op),
        .done     (done),
        .result   (result)
    );

    `include "quaternion_boxplus_boxminus_assert.svh"

    // back end pops whenever the queue is not empty, so the queue never fills
    `QBB_ASSERT_IMP(a_queue_never_full, 1'b1, !fstat.full)
    `QBB_ASSERT_NXT(a_transfer_pushed, start && !busy, push)
    `QBB_ASSERT_IMP(a_busy_only_when_full, busy, fstat.full)

endmodule

// ===== bench/tb_quaternion_boxplus_boxminus.sv =====
module tb_quaternion_boxplus_boxminus;
    import qbb_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    qbb_in_t  item;
    logic     done;
    qbb_out_t result;

    qbb_out_t rotations_due[$];
    bit       failed;
    bit       quiet;

    quaternion_boxplus_boxminus uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_div(longint v, int k, longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = ((mag << k) + n / 2) / n;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic qbb_out_t rotate_and_normalize(qbb_in_t q);
        longint a[4];
        longint b[4];
        longint p[4];
        longint v[4];
        longint o[4];
        longint unsigned m;
        longint unsigned s;
        longint unsigned n;
        longint unsigned mag;
        int len;
        int k;
        qbb_out_t r;
        a[0] = q.base_w;
        a[1] = q.base_x;
        a[2] = q.base_y;
        a[3] = q.base_z;
        b[0] = q.arg_w;
        b[1] = q.arg_x;
        b[2] = q.arg_y;
        b[3] = q.arg_z;
        if (q.mode == MODE_MINUS)
        begin
            a[1] = -a[1];
            a[2] = -a[2];
            a[3] = -a[3];
            k = 30;
        end
        else
        begin
            b[0] = longint'(OneQ30);
            k = 29;
        end
        p[0] = floor_shift(a[0]*b[0], 2) - floor_shift(a[1]*b[1], 2)
             - floor_shift(a[2]*b[2], 2) - floor_shift(a[3]*b[3], 2);
        p[1] = floor_shift(a[0]*b[1], 2) + floor_shift(a[1]*b[0], 2)
             + floor_shift(a[2]*b[3], 2) - floor_shift(a[3]*b[2], 2);
        p[2] = floor_shift(a[0]*b[2], 2) - floor_shift(a[1]*b[3], 2)
             + floor_shift(a[2]*b[0], 2) + floor_shift(a[3]*b[1], 2);
        p[3] = floor_shift(a[0]*b[3], 2) + floor_shift(a[1]*b[2], 2)
             - floor_shift(a[2]*b[1], 2) + floor_shift(a[3]*b[0], 2);
        m = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
            if (mag > m)
                m = mag;
        end
        if (m == 0)
            return '0;
        len = 0;
        while (len < 64 && (m >> len) != 0)
            len++;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (len > 30)
                v[i] = floor_shift(p[i], len - 30);
            else
                v[i] = p[i] <<< (30 - len);
            mag = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            s = s + mag * mag;
        end
        n = int_sqrt(s);
        if (n == 0)
            n = 1;
        for (int i = 0; i < 4; i++)
            o[i] = clamp32(round_div(v[i], k, n));
        r.out_w = (q.mode == MODE_MINUS) ? 32'sd0 : o[0][31:0];
        r.out_x = o[1][31:0];
        r.out_y = o[2][31:0];
        r.out_z = o[3][31:0];
        return r;
    endfunction

    task automatic send_item(qbb_in_t q);
        if (!quiet)
        begin
            while ($urandom_range(99) < 17)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item  <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rotations_due.push_back(rotate_and_normalize(q));
    endtask

    function automatic logic [31:0] pick_field();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
            4: return $urandom_range(32'h4000_0000) - 32'h2000_0000;
            5: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic qbb_in_t random_item();
        qbb_in_t q;
        q.mode   = 1'($urandom_range(1));
        q.base_w = pick_field();
        q.base_x = pick_field();
        q.base_y = pick_field();
        q.base_z = pick_field();
        q.arg_w  = pick_field();
        q.arg_x  = pick_field();
        q.arg_y  = pick_field();
        q.arg_z  = pick_field();
        return q;
    endfunction

    task automatic test_directed();
        qbb_in_t q;
        for (int md = 0; md < 2; md++)
        begin
            q = '0;
            q.mode = 1'(md);
            send_item(q);
            q.base_w = 32'sh2000_0000;
            send_item(q);
            q.arg_w = 32'sh2000_0000;
            q.arg_x = 32'sh0100_0000;
            send_item(q);
            q = '1;
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, {8{32'h8000_0000}}};
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, {8{32'h7fff_ffff}}};
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, 32'sh2000_0000, 32'sh0, 32'sh0, 32'sh0,
                 32'sh0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, 32'sh1, 32'sh0, 32'sh0, 32'sh0,
                 32'sh1, 32'sh0, 32'sh0, 32'sh0};
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, 32'sh0, 32'sh0, 32'sh0, 32'h8000_0000,
                 32'sh0, 32'sh0, 32'sh0, 32'h8000_0000};
            q.mode = 1'(md);
            send_item(q);
            q = {1'b0, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
            q.mode = 1'(md);
            send_item(q);
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 1000; i++)
        begin
            quiet = (i >= 400 && i < 550);
            send_item(random_item());
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        qbb_out_t want;
        if (rst_n && done)
        begin
            if (rotations_due.size() == 0)
            begin
                $display("%0t: result %h with none expected", $time, result);
                failed = 1'b1;
            end
            else
            begin
                want = rotations_due.pop_front();
                if (result.out_w !== want.out_w || result.out_x !== want.out_x ||
                    result.out_y !== want.out_y || result.out_z !== want.out_z)
                begin
                    $display("%0t: expected %h actual %h", $time, want, result);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("tb_quaternion_boxplus_boxminus: FAIL");
        $finish;
    end

    initial
    begin
        failed = 1'b0;
        quiet  = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        item   = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (rotations_due.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (!failed)
            $display("tb_quaternion_boxplus_boxminus: PASS");
        else
            $display("tb_quaternion_boxplus_boxminus: FAIL");
        $finish;
    end
endmodule
